// ===== rtl/rvm_pkg.sv =====
// ----------------------------------------------------------------------------
// rvm_pkg - rotation vector to matrix shared definitions
// Formats, CORDIC constants and the arctangent table.
// ----------------------------------------------------------------------------
package rvm_pkg;

  localparam int InW        = 16;
  localparam int OutW       = 16;
  localparam int CordicN    = 24;
  localparam int SqrtN      = 17;                 // result bits of the root
  localparam int N2W        = 2 * InW + 2;        // squared length width
  localparam int NW         = InW + 1;            // root width
  localparam int AngW       = 34;                 // signed Q.30 angle, covers pi
  localparam int CW         = 34;                 // signed CORDIC datapath width
  localparam int QW         = 32;                 // signed Q.30 quaternion part
  localparam int DivW       = InW + 32;           // dividend magnitude width

  localparam logic signed [AngW-1:0] PiQ30     = 34'sd3373259426;
  localparam logic signed [AngW-1:0] PiHalfQ30 = 34'sd1686629713;
  localparam logic signed [CW-1:0]   GainQ30   = 34'sd652032874;
  localparam logic signed [CW-1:0]   OneQ30    = 34'sd1073741824;

  typedef logic signed [InW-1:0]  in_t;
  typedef logic signed [OutW-1:0] out_t;
  typedef logic signed [CW-1:0]   cw_t;
  typedef logic signed [QW-1:0]   q_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Q.60 sum to Q1.14, round half up, saturate to +-1
  function automatic out_t to_out(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + (64'sd1 <<< (61 - OutW))) >>> (62 - OutW);
    if (r > (64'sd1 <<< (OutW - 2)))       return out_t'(1 << (OutW - 2));
    else if (r < -(64'sd1 <<< (OutW - 2))) return -out_t'(1 << (OutW - 2));
    else                                   return r[OutW-1:0];
  endfunction

  function automatic cw_t clamp_one(input cw_t v);
    if (v > OneQ30)       return OneQ30;
    else if (v < -OneQ30) return -OneQ30;
    else                  return v;
  endfunction

endpackage

// ===== rtl/rotation_vector_to_matrix_unit.sv =====
// ----------------------------------------------------------------------------
// rotation_vector_to_matrix_unit - rotation vector to 3x3 rotation matrix
// Quaternion form of Rodrigues' formula in a fully pipelined datapath.
// ----------------------------------------------------------------------------
// Usage:
//   A vector (rot_x, rot_y, rot_z, signed Q1.14) transfers on a clock edge
//   with start high and busy low. busy is always low: a new vector may be
//   given in every cycle.
//   The nine entries m00..m22 (signed Q1.14, saturated to +-1) appear for one
//   cycle with done high, in input order. A zero vector gives the identity.
//   The pipeline holds 1 square stage, 17 root stages (one bit each),
//   1 angle fold, 24 CORDIC steps, 1 sine/cosine stage, 48 divider stages
//   (one quotient bit each, three dividers side by side) and 3 stages for
//   clamps, products and rounding. Throughput is one vector per cycle.
//   The receiver cannot hold results off, so nothing ever stalls.
//   Synchronous reset clears every valid bit; items in flight are dropped.
// ----------------------------------------------------------------------------
module rotation_vector_to_matrix_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  rvm_pkg::in_t         rot_x,
  input  rvm_pkg::in_t         rot_y,
  input  rvm_pkg::in_t         rot_z,
  output logic                 done,
  output rvm_pkg::out_t        m00,
  output rvm_pkg::out_t        m01,
  output rvm_pkg::out_t        m02,
  output rvm_pkg::out_t        m10,
  output rvm_pkg::out_t        m11,
  output rvm_pkg::out_t        m12,
  output rvm_pkg::out_t        m20,
  output rvm_pkg::out_t        m21,
  output rvm_pkg::out_t        m22
);
  import rvm_pkg::*;

  out_t m [9];

  assign busy = 1'b0;

  rvm_core u_core (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (start),
    .in_x    (rot_x),
    .in_y    (rot_y),
    .in_z    (rot_z),
    .out_vld (done),
    .out_m   (m)
  );

  assign m00 = m[0];
  assign m01 = m[1];
  assign m02 = m[2];
  assign m10 = m[3];
  assign m11 = m[4];
  assign m12 = m[5];
  assign m20 = m[6];
  assign m21 = m[7];
  assign m22 = m[8];

endmodule

// ===== rtl/rvm_core.sv =====
// ----------------------------------------------------------------------------
// rvm_core - rotation vector to matrix pipeline
// Squares, root, CORDIC, three dividers and matrix products, all pipelined.
// ----------------------------------------------------------------------------
module rvm_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  input  rvm_pkg::in_t       in_x,
  input  rvm_pkg::in_t       in_y,
  input  rvm_pkg::in_t       in_z,
  output logic               out_vld,
  output rvm_pkg::out_t      out_m [9]
);
  import rvm_pkg::*;

  // total stages: 1 square + SqrtN root + 1 angle + CordicN + 1 sin/cos
  // + DivW divide + 1 clamp + 1 products + 1 sums
  localparam int Lat = 1 + SqrtN + 1 + CordicN + 1 + DivW + 3;

  logic [Lat-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else     vld <= {vld[Lat-2:0], in_vld};
  end
  assign out_vld = vld[Lat-1];

  // ---------------- stage: squares, loaded into the head of the root chain
  logic [N2W-1:0] sq_rem  [SqrtN+1];
  logic [N2W-1:0] sq_root [SqrtN+1];
  logic [N2W-1:0] sq_n2   [SqrtN+1];
  in_t            sq_r    [SqrtN+1][3];
  logic signed [2*InW-1:0] sq_x, sq_y, sq_z;
  logic [N2W-1:0] n2_sum;
  assign sq_x = (2*InW)'(in_x) * (2*InW)'(in_x);
  assign sq_y = (2*InW)'(in_y) * (2*InW)'(in_y);
  assign sq_z = (2*InW)'(in_z) * (2*InW)'(in_z);
  assign n2_sum = N2W'($unsigned(sq_x)) + N2W'($unsigned(sq_y))
                + N2W'($unsigned(sq_z));
  always_ff @(posedge clk) begin
    sq_rem[0]  <= n2_sum;
    sq_root[0] <= '0;
    sq_n2[0]   <= n2_sum;
    sq_r[0][0] <= in_x;
    sq_r[0][1] <= in_y;
    sq_r[0][2] <= in_z;
  end

  // ---------------- root: one result bit per stage
  for (genvar k = 0; k < SqrtN; k++) begin : g_sqrt
    localparam int Sh = 2 * (SqrtN - 1 - k);
    logic [N2W-1:0] bitv, trial;
    assign bitv  = N2W'(1) << Sh;
    assign trial = sq_root[k] + bitv;
    always_ff @(posedge clk) begin
      sq_n2[k+1] <= sq_n2[k];
      sq_r[k+1]  <= sq_r[k];
      if (sq_rem[k] >= trial) begin
        sq_rem[k+1]  <= sq_rem[k] - trial;
        sq_root[k+1] <= (sq_root[k] >> 1) + bitv;
      end else begin
        sq_rem[k+1]  <= sq_rem[k];
        sq_root[k+1] <= sq_root[k] >> 1;
      end
    end
  end

  // ---------------- angle and fold, loaded into the head of the CORDIC chain
  cw_t           cx [CordicN+1], cy [CordicN+1], cz [CordicN+1];
  logic [NW-1:0] cn [CordicN+1];
  logic          czero [CordicN+1], cfold [CordicN+1];
  in_t           cr [CordicN+1][3];
  logic signed [AngW-1:0] phi_raw;
  assign phi_raw = AngW'({1'b0, sq_root[SqrtN][NW-1:0]}) <<< (32 - InW);
  always_ff @(posedge clk) begin
    cx[0]    <= GainQ30;
    cy[0]    <= '0;
    cz[0]    <= (phi_raw > PiHalfQ30) ? PiQ30 - phi_raw : phi_raw;
    cn[0]    <= sq_root[SqrtN][NW-1:0];
    czero[0] <= (sq_n2[SqrtN] == '0);
    cfold[0] <= phi_raw > PiHalfQ30;
    cr[0]    <= sq_r[SqrtN];
  end

  // ---------------- CORDIC, one step per stage
  for (genvar i = 0; i < CordicN; i++) begin : g_cordic
    cw_t at;
    assign at = cw_t'({2'b00, atan_q30(5'(i))});
    always_ff @(posedge clk) begin
      cn[i+1] <= cn[i]; czero[i+1] <= czero[i];
      cfold[i+1] <= cfold[i]; cr[i+1] <= cr[i];
      if (!cz[i][CW-1]) begin
        cx[i+1] <= cx[i] - (cy[i] >>> i);
        cy[i+1] <= cy[i] + (cx[i] >>> i);
        cz[i+1] <= cz[i] - at;
      end else begin
        cx[i+1] <= cx[i] + (cy[i] >>> i);
        cy[i+1] <= cy[i] - (cx[i] >>> i);
        cz[i+1] <= cz[i] + at;
      end
    end
  end

  // ---------------- sin/cos clamp and numerators x*s, into the divider head
  logic [DivW-1:0] dq [DivW+1][3];
  logic [NW:0]     dr [DivW+1][3];
  logic            dneg [DivW+1][3];
  logic [NW-1:0]   dn [DivW+1];
  cw_t             dc [DivW+1];
  logic            dzero [DivW+1];
  cw_t             s_cl;
  assign s_cl = clamp_one(cy[CordicN]);
  always_ff @(posedge clk) begin
    dc[0]    <= clamp_one(cfold[CordicN] ? -cx[CordicN] : cx[CordicN]);
    dn[0]    <= cn[CordicN];
    dzero[0] <= czero[CordicN];
    for (int j = 0; j < 3; j++) begin
      logic signed [InW+CW-1:0] p;
      p = cr[CordicN][j] * s_cl;
      dneg[0][j] <= p[InW+CW-1];
      dr[0][j]   <= '0;
      dq[0][j]   <= DivW'(p[InW+CW-1] ? -p : p);
    end
  end

  // ---------------- restoring dividers, one quotient bit per stage
  for (genvar t = 0; t < DivW; t++) begin : g_div
    always_ff @(posedge clk) begin
      dn[t+1] <= dn[t]; dc[t+1] <= dc[t]; dzero[t+1] <= dzero[t];
      for (int j = 0; j < 3; j++) begin
        logic [NW:0] sh;
        sh = {dr[t][j][NW-1:0], dq[t][j][DivW-1]};
        dneg[t+1][j] <= dneg[t][j];
        if (sh >= {1'b0, dn[t]}) begin
          dr[t+1][j] <= sh - {1'b0, dn[t]};
          dq[t+1][j] <= {dq[t][j][DivW-2:0], 1'b1};
        end else begin
          dr[t+1][j] <= sh;
          dq[t+1][j] <= {dq[t][j][DivW-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------- quaternion clamp
  cw_t  e_q [3];
  cw_t  e_c;
  logic e_zero;
  always_ff @(posedge clk) begin
    e_c    <= dc[DivW];
    e_zero <= dzero[DivW];
    for (int j = 0; j < 3; j++) begin
      logic [DivW-1:0] qm;
      qm = dq[DivW][j];
      if (qm > DivW'(1 << 30)) e_q[j] <= dneg[DivW][j] ? -OneQ30 : OneQ30;
      else e_q[j] <= dneg[DivW][j] ? -cw_t'(qm) : cw_t'(qm);
    end
  end

  // ---------------- products (31x31 bit each)
  logic signed [63:0] p_cc, p_aa, p_bb, p_dd, p_ab, p_ad, p_bd, p_ca, p_cb, p_cd;
  logic               p_zero;
  always_ff @(posedge clk) begin
    p_zero <= e_zero;
    p_cc <= 64'(e_c * e_c);       p_aa <= 64'(e_q[0] * e_q[0]);
    p_bb <= 64'(e_q[1] * e_q[1]); p_dd <= 64'(e_q[2] * e_q[2]);
    p_ab <= 64'(e_q[0] * e_q[1]); p_ad <= 64'(e_q[0] * e_q[2]);
    p_bd <= 64'(e_q[1] * e_q[2]); p_ca <= 64'(e_c * e_q[0]);
    p_cb <= 64'(e_c * e_q[1]);    p_cd <= 64'(e_c * e_q[2]);
  end

  // ---------------- sums, rounding, saturation
  out_t one_o;
  assign one_o = out_t'(1 << (OutW - 2));
  always_ff @(posedge clk) begin
    if (p_zero) begin
      for (int j = 0; j < 9; j++) out_m[j] <= (j % 4 == 0) ? one_o : '0;
    end else begin
      out_m[0] <= to_out(p_cc + p_aa - p_bb - p_dd);
      out_m[1] <= to_out((p_ab - p_cd) <<< 1);
      out_m[2] <= to_out((p_ad + p_cb) <<< 1);
      out_m[3] <= to_out((p_ab + p_cd) <<< 1);
      out_m[4] <= to_out(p_cc - p_aa + p_bb - p_dd);
      out_m[5] <= to_out((p_bd - p_ca) <<< 1);
      out_m[6] <= to_out((p_ad - p_cb) <<< 1);
      out_m[7] <= to_out((p_bd + p_ca) <<< 1);
      out_m[8] <= to_out(p_cc - p_aa - p_bb + p_dd);
    end
  end

endmodule

// ===== sim/rotation_vector_to_matrix_unit_test.sv =====
// ----------------------------------------------------------------------------
// rotation_vector_to_matrix_unit_test - self-checking bench for the unit
// Drives rotation vectors in random bursts, predicts each matrix (typed rows
// apart) with an independent fixed-point model, compares all nine in order.
// ----------------------------------------------------------------------------
module rotation_vector_to_matrix_unit_test;
  import rvm_pkg::*;

  typedef logic [8:0][OutW-1:0] matrix_t;

  localparam int TailCycles = 120;
  localparam longint OneQ14 = 64'sd1 <<< (OutW - 2);
  localparam longint TurnQ30 [24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  in_t     rot_x = '0, rot_y = '0, rot_z = '0;
  logic    done;
  out_t    m00, m01, m02, m10, m11, m12, m20, m21, m22;

  matrix_t matrix_queue[$];
  logic    typed_valid = 1'b0;
  matrix_t typed_matrix;
  int      fail_count = 0;

  rotation_vector_to_matrix_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z), .done(done),
    .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
    .m20(m20), .m21(m21), .m22(m22)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint lim(longint v, longint l);
    if (v > l) return l;
    if (v < -l) return -l;
    return v;
  endfunction

  function automatic logic [OutW-1:0] q60_to_q14(longint v);
    longint r;
    r = lim((v + (64'sd1 <<< (61 - OutW))) >>> (62 - OutW), OneQ14);
    return r[OutW-1:0];
  endfunction

  function automatic matrix_t rodrigues(in_t x, in_t y, in_t z);
    longint r [3];
    longint q [3];
    longint unsigned n2, n, rem, root, bitv;
    longint phi, cx, cy, cz, dx, dy, c, s, a, b, d;
    logic fold;
    matrix_t m;
    r[0] = x; r[1] = y; r[2] = z;
    n2 = r[0] * r[0] + r[1] * r[1] + r[2] * r[2];
    if (n2 == 0) begin
      m = '0;
      m[0] = OneQ14[OutW-1:0]; m[4] = OneQ14[OutW-1:0]; m[8] = OneQ14[OutW-1:0];
      return m;
    end
    rem = n2; root = 0; bitv = 64'd1 << 62;
    while (bitv > n2) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    n = root;
    phi = longint'(n << (32 - InW));
    fold = phi > 64'sd1686629713;
    if (fold) phi = 64'sd3373259426 - phi;
    cx = 64'sd652032874; cy = 0; cz = phi;
    for (int i = 0; i < 24; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cz >= 0) begin
        cx -= dx; cy += dy; cz -= TurnQ30[i];
      end else begin
        cx += dx; cy -= dy; cz += TurnQ30[i];
      end
    end
    c = lim(fold ? -cx : cx, 64'sd1 <<< 30);
    s = lim(cy, 64'sd1 <<< 30);
    for (int i = 0; i < 3; i++) q[i] = lim((r[i] * s) / longint'(n), 64'sd1 <<< 30);
    a = q[0]; b = q[1]; d = q[2];
    m[0] = q60_to_q14(c * c + a * a - b * b - d * d);
    m[1] = q60_to_q14(2 * (a * b - c * d));
    m[2] = q60_to_q14(2 * (a * d + c * b));
    m[3] = q60_to_q14(2 * (a * b + c * d));
    m[4] = q60_to_q14(c * c - a * a + b * b - d * d);
    m[5] = q60_to_q14(2 * (b * d - c * a));
    m[6] = q60_to_q14(2 * (a * d - c * b));
    m[7] = q60_to_q14(2 * (b * d + c * a));
    m[8] = q60_to_q14(c * c - a * a - b * b + d * d);
    return m;
  endfunction

  // record each input transfer and check each result against the oldest matrix
  always @(posedge clk) begin
    matrix_t got, want;
    string   names [9];
    names = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};
    if (!rst && start && !busy)
      matrix_queue.insert(matrix_queue.size(),
                          typed_valid ? typed_matrix : rodrigues(rot_x, rot_y, rot_z));
    if (!rst && done) begin
      got = {m22, m21, m20, m12, m11, m10, m02, m01, m00};
      if (matrix_queue.size() == 0) begin
        $error("result with no matrix waiting");
        fail_count++;
      end else begin
        want = matrix_queue.pop_front();
        for (int k = 0; k < 9; k++)
          if (got[k] !== want[k]) begin
            $error("%s expected %0d actual %0d", names[k],
                   $signed(want[k]), $signed(got[k]));
            fail_count++;
          end
      end
    end
  end

  int burst_left = 0;

  task automatic send(in_t x, in_t y, in_t z, logic typed, matrix_t tm);
    int gap;
    @(negedge clk);
    rot_x <= x; rot_y <= y; rot_z <= z;
    typed_valid <= typed; typed_matrix <= tm;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        @(negedge clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  typedef struct {
    in_t x, y, z;
    logic typed;
  } vector_row_t;

  // zero vector rows carry the identity; the rest go through the predictor
  vector_row_t directed [18] = '{
    '{16'sd0, 16'sd0, 16'sd0, 1'b1},
    '{16'sd1, 16'sd0, 16'sd0, 1'b0},
    '{16'sd0, -16'sd1, 16'sd0, 1'b0},
    '{16'sd0, 16'sd0, 16'sd1, 1'b0},
    '{16'sd32767, 16'sd0, 16'sd0, 1'b0},
    '{-16'sd32768, 16'sd0, 16'sd0, 1'b0},
    '{16'sd0, -16'sd32768, 16'sd0, 1'b0},
    '{16'sd0, 16'sd0, -16'sd32768, 1'b0},
    '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0},
    '{16'sd32767, 16'sd32767, 16'sd32767, 1'b0},
    '{16'sd32767, -16'sd32768, 16'sd32767, 1'b0},
    '{16'sd25736, 16'sd0, 16'sd0, 1'b0},
    '{16'sd25737, 16'sd0, 16'sd0, 1'b0},
    '{16'sd0, 16'sd28672, 16'sd0, 1'b0},
    '{16'sd12868, 16'sd0, 16'sd0, 1'b0},
    '{16'sd1, 16'sd1, -16'sd1, 1'b0},
    '{16'sd0, 16'sd0, 16'sd0, 1'b1},
    '{16'sd4096, -16'sd8192, 16'sd2048, 1'b0}
  };

  initial begin
    matrix_t ident;
    in_t     v [3];
    ident = '0;
    ident[0] = OneQ14[OutW-1:0]; ident[4] = OneQ14[OutW-1:0]; ident[8] = OneQ14[OutW-1:0];
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed[i])
      send(directed[i].x, directed[i].y, directed[i].z, directed[i].typed, ident);
    for (int n = 0; n < 400; n++) begin
      for (int k = 0; k < 3; k++)
        case ($urandom_range(0, 5))
          0: v[k] = in_t'($urandom_range(0, 15)) - in_t'(8);
          1: v[k] = ($urandom_range(0, 1) != 0) ? 16'sd32767 : -16'sd32768;
          2: v[k] = in_t'($urandom_range(0, 2047)) - in_t'(1024);
          3: v[k] = '0;
          default: v[k] = in_t'($urandom());
        endcase
      send(v[0], v[1], v[2], 1'b0, ident);
      if (n == 200) begin
        // hold off until the pipeline has drained
        @(negedge clk);
        start <= 1'b0;
        while (matrix_queue.size() != 0) @(negedge clk);
      end
    end
    @(negedge clk);
    start <= 1'b0;
    while (matrix_queue.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rvm_pkg.sv
rtl/rvm_core.sv
rtl/rotation_vector_to_matrix_unit.sv
sim/rotation_vector_to_matrix_unit_test.sv
